// ----- design/tcp_byte_ring_buffer_defines.svh -----
// assertion macros for the ring buffer datapath
`ifndef TCP_BYTE_RING_BUFFER_DEFINES_SVH
`define TCP_BYTE_RING_BUFFER_DEFINES_SVH
`ifndef SYNTH
`define TBRB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tcp_byte_ring_buffer: invariant violated");
`define TBRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcp_byte_ring_buffer: implication violated");
`else
`define TBRB_ASSERT(lbl, clk, rst_n, prop)
`define TBRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/tbrb_pkg.sv -----
// types and constants of the byte ring buffer
`timescale 1ns / 1ps
`default_nettype none
package tbrb_pkg;

	localparam int CMD_W    = 3;
	localparam int SIZE_W   = 13;
	localparam int AMT_W    = 7;
	localparam int DATA_W   = 64;
	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 3;
	localparam int APB_W    = 32;

	localparam int SIZE_RESET = 4096;
	localparam int WRITE_MAX  = 8;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RWRITE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COMMIT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

	// register index, taken from paddr[2]
	localparam logic REG_BUFFER_SIZE = 1'b0;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [SIZE_W-1:0] offset;
		logic [AMT_W-1:0]  amount;
		logic [DATA_W-1:0] data_in;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              byte_valid;
		logic              last;
		logic [SIZE_W-1:0] amount_done;
		logic              overflow;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_WRITE,
		ST_UPDATE,
		ST_PK_RD,
		ST_PK_OUT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic wr_byte;
		logic update;
		logic rd_issue;
		logic pk_load;
		logic resp_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             wr_last;
		logic             pk_last;
		logic             none;
		logic             out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- design/tbrb_if.sv -----
// valid/ready channel interfaces for items in and results out
`timescale 1ns / 1ps
`default_nettype none
interface tbrb_req_if;
	logic                         valid;
	logic                         ready;
	logic [tbrb_pkg::CMD_W-1:0]   command;
	logic [tbrb_pkg::SIZE_W-1:0]  offset;
	logic [tbrb_pkg::AMT_W-1:0]   amount;
	logic [tbrb_pkg::DATA_W-1:0]  data_in;

	modport source(output valid, output command, output offset, output amount,
		output data_in, input ready);
	modport sink(input valid, input command, input offset, input amount,
		input data_in, output ready);
endinterface

interface tbrb_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [tbrb_pkg::BYTE_W-1:0]  data_byte;
	logic                         byte_valid;
	logic                         last;
	logic [tbrb_pkg::SIZE_W-1:0]  amount_done;
	logic                         overflow;

	modport source(output valid, output data_byte, output byte_valid, output last,
		output amount_done, output overflow, input ready);
	modport sink(input valid, input data_byte, input byte_valid, input last,
		input amount_done, input overflow, output ready);
endinterface
`default_nettype wire

// ----- design/tbrb_ctrl.sv -----
// sequencing state machine of the byte ring buffer
`timescale 1ns / 1ps
`default_nettype none
module tbrb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tbrb_pkg::dp_sts_t sts,
	output tbrb_pkg::dp_cmd_t ctl
);
	import tbrb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CALC;
			end
			ST_CALC: begin
				case (sts.cmd)
					CMD_APPEND, CMD_RWRITE: state_d = ST_WRITE;
					CMD_PEEK:               state_d = ST_PK_RD;
					CMD_COMMIT, CMD_REMOVE: state_d = ST_UPDATE;
					default:                state_d = ST_RESP;
				endcase
			end
			ST_WRITE: begin
				if (sts.wr_last) state_d = (sts.cmd == CMD_APPEND) ? ST_UPDATE : ST_RESP;
			end
			ST_UPDATE: begin
				state_d = ST_RESP;
			end
			ST_PK_RD: begin
				// nothing to peek gives one empty result
				state_d = sts.none ? ST_RESP : ST_PK_OUT;
			end
			ST_PK_OUT: begin
				if (sts.out_free) state_d = sts.pk_last ? ST_IDLE : ST_PK_RD;
			end
			ST_RESP: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			ST_CALC:   ctl.calc      = 1'b1;
			ST_WRITE:  ctl.wr_byte   = 1'b1;
			ST_UPDATE: ctl.update    = 1'b1;
			ST_PK_RD:  ctl.rd_issue  = 1'b1;
			ST_PK_OUT: ctl.pk_load   = sts.out_free;
			ST_RESP:   ctl.resp_load = sts.out_free;
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- design/tbrb_dp.sv -----
// datapath: ring memory, pointers, fill count, clamping and result register
`timescale 1ns / 1ps
`default_nettype none
`include "tcp_byte_ring_buffer_defines.svh"
module tbrb_dp #(
	parameter int DEPTH    = 4096,
	parameter int MAX_PEEK = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tbrb_pkg::SIZE_W-1:0] cfg_size,
	output logic [tbrb_pkg::SIZE_W-1:0] size_reg,
	input  tbrb_pkg::item_t             item,
	input  tbrb_pkg::dp_cmd_t           ctl,
	output tbrb_pkg::dp_sts_t           sts,
	output logic                        out_valid,
	input  logic                        out_ready,
	output tbrb_pkg::result_t           result
);
	import tbrb_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = ((PW + 1 > SIZE_W) ? PW + 1 : SIZE_W) + 2;
	localparam logic [CW-1:0] DEPTH_W = CW'(DEPTH);
	localparam logic [CW-1:0] MAXPK_W = CW'(MAX_PEEK);
	localparam logic [CW-1:0] WMAX_W  = CW'(WRITE_MAX);
	localparam logic [CW-1:0] RST_LEN = (SIZE_RESET > DEPTH) ? CW'(DEPTH) : CW'(SIZE_RESET);

	function automatic logic [CW-1:0] ring_len(input logic [SIZE_W-1:0] sz);
		logic [CW-1:0] v;
		v = CW'(sz);
		if (v == '0) return CW'(1);
		if (v > DEPTH_W) return DEPTH_W;
		return v;
	endfunction

	function automatic logic [CW-1:0] wrap(input logic [CW-1:0] v, input logic [CW-1:0] len);
		return (v >= len) ? v - len : v;
	endfunction

	function automatic logic [CW-1:0] min2(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return (a > b) ? b : a;
	endfunction

	logic [SIZE_W-1:0] size_q;
	logic [CW-1:0]     len_q;
	logic [PW-1:0]     wp_q;
	logic [PW-1:0]     rp_q;
	logic [CW-1:0]     fill_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [SIZE_W-1:0] off_q;
	logic [AMT_W-1:0]  amt_q;
	logic [DATA_W-1:0] data_q;
	logic [SIZE_W-1:0] done_q;
	logic              ovf_q;
	logic              ok_q;
	logic [PW-1:0]     pos_q;
	logic [AMT_W-1:0]  idx_q;
	logic [BYTE_W-1:0] rd_data_q;
	logic              out_valid_q;
	result_t           res_q;

	logic [BYTE_W-1:0] mem [DEPTH];

	logic [CW-1:0] space, off_w, amt_w, n8, npk, room_rw, avail;
	logic [CW-1:0] done_c, wp_w, rp_w, done_w, adv;
	logic          ovf_c, ok_c;
	logic [PW-1:0] pos_c, pos_inc;
	logic [CW-1:0] pos_nx;
	logic          idx_lt_done;

	assign space   = len_q - fill_q;
	assign off_w   = CW'(off_q);
	assign amt_w   = CW'(amt_q);
	assign wp_w    = CW'(wp_q);
	assign rp_w    = CW'(rp_q);
	assign done_w  = CW'(done_q);
	assign n8      = min2(amt_w, WMAX_W);
	assign npk     = min2(amt_w, MAXPK_W);
	assign room_rw = (off_w < space) ? space - off_w : '0;
	assign avail   = (fill_q > off_w) ? fill_q - off_w : '0;
	assign ok_c    = (off_w <= space);

	// clamp the request against fill and free space
	always_comb begin
		done_c = '0;
		ovf_c  = 1'b0;
		pos_c  = wp_q;
		case (cmd_q)
			CMD_APPEND: begin
				done_c = min2(n8, space);
				ovf_c  = (n8 > space);
			end
			CMD_RWRITE: begin
				done_c = min2(n8, room_rw);
				ovf_c  = (n8 > room_rw);
				pos_c  = PW'(wrap(wp_w + off_w, len_q));
			end
			CMD_PEEK: begin
				done_c = min2(npk, avail);
				pos_c  = PW'(wrap(rp_w + off_w, len_q));
			end
			CMD_COMMIT: begin
				done_c = ok_c ? min2(amt_w, space - off_w) : '0;
			end
			CMD_REMOVE: begin
				done_c = min2(amt_w, fill_q);
			end
			default: begin
				done_c = '0;
			end
		endcase
	end

	assign adv         = done_w + ((cmd_q == CMD_COMMIT) ? off_w : '0);
	assign pos_nx      = CW'(pos_q) + CW'(1);
	assign pos_inc     = (pos_nx >= len_q) ? '0 : pos_nx[PW-1:0];
	assign idx_lt_done = (SIZE_W'(idx_q) < done_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(SIZE_RESET);
			len_q  <= RST_LEN;
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_size;
			len_q  <= ring_len(cfg_size);
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else if (ctl.update) begin
			case (cmd_q)
				CMD_APPEND: begin
					wp_q   <= PW'(wrap(wp_w + adv, len_q));
					fill_q <= fill_q + done_w;
				end
				CMD_COMMIT: begin
					// offset beyond free space leaves the ring untouched
					if (ok_q) begin
						wp_q   <= PW'(wrap(wp_w + adv, len_q));
						fill_q <= fill_q + done_w;
					end
				end
				CMD_REMOVE: begin
					rp_q   <= PW'(wrap(rp_w + done_w, len_q));
					fill_q <= fill_q - done_w;
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			idx_q <= '0;
		end else if (ctl.calc) begin
			pos_q <= pos_c;
			idx_q <= '0;
		end else if ((ctl.wr_byte && idx_lt_done) || ctl.pk_load) begin
			pos_q <= pos_inc;
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= item.command;
			off_q  <= item.offset;
			amt_q  <= item.amount;
			data_q <= item.data_in;
		end
		if (ctl.calc) begin
			done_q <= done_c[SIZE_W-1:0];
			ovf_q  <= ovf_c;
			ok_q   <= ok_c;
		end
	end

	// byte-wide ring memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_byte && idx_lt_done) begin
			mem[pos_q] <= data_q[{idx_q[2:0], 3'b000} +: BYTE_W];
		end
		if (ctl.rd_issue) begin
			rd_data_q <= mem[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.pk_load || ctl.resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pk_load) begin
			res_q.data_byte   <= rd_data_q;
			res_q.byte_valid  <= 1'b1;
			res_q.last        <= sts.pk_last;
			res_q.amount_done <= done_q;
			res_q.overflow    <= 1'b0;
		end else if (ctl.resp_load) begin
			res_q.data_byte   <= '0;
			res_q.byte_valid  <= 1'b0;
			res_q.last        <= 1'b1;
			res_q.amount_done <= done_q;
			res_q.overflow    <= ovf_q;
		end
	end

	assign sts.cmd      = cmd_q;
	assign sts.wr_last  = (SIZE_W'(idx_q) + 1'b1 >= done_q);
	assign sts.pk_last  = (SIZE_W'(idx_q) + 1'b1 == done_q);
	assign sts.none     = (done_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	assign size_reg  = size_q;
	assign out_valid = out_valid_q;
	assign result    = res_q;

	`TBRB_ASSERT(a_fill_fits, clk, arst_n, fill_q <= len_q)
	`TBRB_ASSERT(a_wp_in_ring, clk, arst_n, CW'(wp_q) < len_q)
	`TBRB_ASSERT(a_rp_in_ring, clk, arst_n, CW'(rp_q) < len_q)
	`TBRB_ASSERT_IMP(a_load_free, clk, arst_n, ctl.pk_load || ctl.resp_load, !out_valid_q || out_ready)

endmodule
`default_nettype wire

// ----- design/tcp_byte_ring_buffer.sv -----
// Byte ring buffer with append, peek, receive write, receive commit and remove.
// Items are handled one at a time through a single byte-wide memory port with a
// registered read. Append and receive write store the clamped bytes one at a
// time, then append moves the write pointer; peek reads and emits each byte in
// turn, or gives one empty result; commit and remove update a pointer and fill
// count; unknown commands only respond. A stalled result output adds its wait. A
// finished result waits in an output register while the next item is taken.
// Writing buffer_size (byte address 0) clears both pointers and the fill count
// but keeps stored bytes; write it only while the block is idle. The store has
// no reset and no clearing pass: peeking bytes never written returns unspecified
// data.
`timescale 1ns / 1ps
`default_nettype none
module tcp_byte_ring_buffer #(
	parameter int DEPTH    = 4096,
	parameter int MAX_PEEK = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tbrb_pkg::ADDR_W-1:0] paddr,
	input  logic [tbrb_pkg::APB_W-1:0]  pwdata,
	output logic [tbrb_pkg::APB_W-1:0]  prdata,
	output logic                        pready,
	tbrb_req_if.sink                    req,
	tbrb_rsp_if.source                  rsp
);
	import tbrb_pkg::*;

	logic              cfg_we;
	logic [SIZE_W-1:0] size_reg;
	logic              in_ready;
	logic              out_valid;
	item_t             item;
	result_t           result;
	dp_cmd_t           ctl;
	dp_sts_t           sts;

	// register index is paddr[2], other addresses are ignored
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_BUFFER_SIZE);
	assign prdata = (paddr[2] == REG_BUFFER_SIZE) ? APB_W'(size_reg) : '0;

	assign item.command = req.command;
	assign item.offset  = req.offset;
	assign item.amount  = req.amount;
	assign item.data_in = req.data_in;
	assign req.ready    = in_ready;

	assign rsp.valid       = out_valid;
	assign rsp.data_byte   = result.data_byte;
	assign rsp.byte_valid  = result.byte_valid;
	assign rsp.last        = result.last;
	assign rsp.amount_done = result.amount_done;
	assign rsp.overflow    = result.overflow;

	tbrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	tbrb_dp #(
		.DEPTH    (DEPTH),
		.MAX_PEEK (MAX_PEEK)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_size  (pwdata[SIZE_W-1:0]),
		.size_reg  (size_reg),
		.item      (item),
		.ctl       (ctl),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.result    (result)
	);

endmodule
`default_nettype wire

// ----- bench/tcp_byte_ring_buffer_checker.sv -----
// scoreboard for the byte ring buffer: tracks ring state and checks every result item
`timescale 1ns / 1ps
module tcp_byte_ring_buffer_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tbrb_pkg::ADDR_W-1:0] paddr,
	input  logic [tbrb_pkg::APB_W-1:0]  pwdata,
	input  logic                        pready,
	tbrb_req_if                         req,
	tbrb_rsp_if                         rsp,
	output int                          errors,
	output int                          pending,
	output int                          checked_count,
	output int                          peeked_count,
	output int                          overflow_count,
	output int unsigned                 ring_span,
	output int unsigned                 head_at,
	output int unsigned                 bytes_held,
	output logic [4095:0]               byte_written
);
	import tbrb_pkg::*;

	localparam int RING_DEPTH = 4096;
	localparam int PEEK_MAX   = 64;

	logic [SIZE_W-1:0] size_reg;
	logic [11:0]       wr_ptr;
	logic [11:0]       rd_ptr;
	logic [SIZE_W-1:0] fill_reg;
	logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
	result_t           ring_results_due [$];

	function automatic int unsigned effective_len(logic [SIZE_W-1:0] s);
		if (s == '0) return 1;
		if (s > RING_DEPTH) return RING_DEPTH;
		return 32'(s);
	endfunction

	function automatic int unsigned wrap_ring(int unsigned v, int unsigned len);
		return (v >= len) ? v - len : v;
	endfunction

	function automatic result_t ring_result(logic [BYTE_W-1:0] b, logic v, logic l,
		int unsigned d, logic o);
		result_t r;
		r.data_byte   = b;
		r.byte_valid  = v;
		r.last        = l;
		r.amount_done = SIZE_W'(d);
		r.overflow    = o;
		return r;
	endfunction

	assign ring_span  = effective_len(size_reg);
	assign head_at    = 32'(rd_ptr);
	assign bytes_held = 32'(fill_reg);

	task automatic predict_ring_op(input item_t it);
		int unsigned len, fill, space, n, done, pos, avail, off, amt, i;
		logic ovf;
		len = effective_len(size_reg);
		fill = (32'(fill_reg) > len) ? len : 32'(fill_reg);
		space = len - fill;
		wr_ptr = 12'(wrap_ring(32'(wr_ptr), len) % len);
		rd_ptr = 12'(wrap_ring(32'(rd_ptr), len) % len);
		fill_reg = SIZE_W'(fill);
		off = 32'(it.offset);
		amt = 32'(it.amount);
		done = 0;
		ovf = 1'b0;
		case (it.command)
			CMD_APPEND: begin
				n = (amt > WRITE_MAX) ? WRITE_MAX : amt;
				done = (n > space) ? space : n;
				ovf = (n > space);
				for (i = 0; i < done; i++) begin
					ring_mem[wr_ptr] = it.data_in[8*i +: 8];
					byte_written[wr_ptr] = 1'b1;
					wr_ptr = 12'(wrap_ring(32'(wr_ptr) + 1, len));
				end
				fill_reg = SIZE_W'(fill + done);
			end
			CMD_PEEK: begin
				avail = (fill > off) ? fill - off : 0;
				n = (amt > PEEK_MAX) ? PEEK_MAX : amt;
				if (n > avail) n = avail;
				// an empty peek falls through to the single zero result below
				if (n != 0) begin
					pos = wrap_ring(32'(rd_ptr) + off, len);
					for (i = 0; i < n; i++) begin
						ring_results_due.push_back(ring_result(ring_mem[12'(pos)], 1'b1,
							i + 1 == n, n, 1'b0));
						pos = wrap_ring(pos + 1, len);
					end
					peeked_count += n;
					return;
				end
			end
			CMD_RWRITE: begin
				n = (amt > WRITE_MAX) ? WRITE_MAX : amt;
				for (i = 0; i < n; i++) begin
					if (off + i < space) begin
						pos = wrap_ring(32'(wr_ptr) + off + i, len);
						ring_mem[12'(pos)] = it.data_in[8*i +: 8];
						byte_written[12'(pos)] = 1'b1;
						done++;
					end else begin
						ovf = 1'b1;
					end
				end
			end
			CMD_COMMIT: begin
				if (off <= space) begin
					done = (amt > space - off) ? space - off : amt;
					wr_ptr = 12'(wrap_ring(32'(wr_ptr) + off + done, len));
					fill_reg = SIZE_W'(fill + done);
				end
			end
			CMD_REMOVE: begin
				done = (amt > fill) ? fill : amt;
				rd_ptr = 12'(wrap_ring(32'(rd_ptr) + done, len));
				fill_reg = SIZE_W'(fill - done);
			end
			default: ;
		endcase
		ring_results_due.push_back(ring_result('0, 1'b0, 1'b1, done, ovf));
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	task automatic compare_result(input result_t got);
		result_t want;
		checked_count++;
		if (got.overflow) overflow_count++;
		if (ring_results_due.size() == 0) begin
			errors++;
			$display("%0t: result item with none due: expected nothing, actual %h", $time, got);
			return;
		end
		want = ring_results_due.pop_front();
		check_field("data_byte", want.data_byte, got.data_byte);
		check_field("byte_valid", want.byte_valid, got.byte_valid);
		check_field("last", want.last, got.last);
		check_field("amount_done", want.amount_done, got.amount_done);
		check_field("overflow", want.overflow, got.overflow);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		item_t   it;
		if (!arst_n) begin
			size_reg = SIZE_W'(SIZE_RESET);
			wr_ptr = '0;
			rd_ptr = '0;
			fill_reg = '0;
			byte_written = '0;
			ring_results_due.delete();
			errors = 0;
			pending = 0;
			checked_count = 0;
			peeked_count = 0;
			overflow_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.data_byte = rsp.data_byte;
				got.byte_valid = rsp.byte_valid;
				got.last = rsp.last;
				got.amount_done = rsp.amount_done;
				got.overflow = rsp.overflow;
				compare_result(got);
			end
			// a size write restarts the ring but keeps the stored bytes
			if (psel && penable && pwrite && pready && paddr[2] == REG_BUFFER_SIZE) begin
				size_reg = pwdata[SIZE_W-1:0];
				wr_ptr = '0;
				rd_ptr = '0;
				fill_reg = '0;
			end
			if (req.valid && req.ready) begin
				it.command = req.command;
				it.offset = req.offset;
				it.amount = req.amount;
				it.data_in = req.data_in;
				predict_ring_op(it);
			end
			pending = ring_results_due.size();
		end
	end

endmodule

// ----- bench/tcp_byte_ring_buffer_test.sv -----
// stimulus and verdict for the byte ring buffer
`timescale 1ns / 1ps
module tcp_byte_ring_buffer_test;
	import tbrb_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;
	localparam int               PEEK_MAX       = 64;
	localparam int               OFFSET_TOP     = 8191;
	localparam int               AMOUNT_TOP     = 127;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_W-1:0]  pwdata;
	logic [APB_W-1:0]  prdata;
	logic              pready;
	logic              calm = 1'b0;
	int                stall_left;
	int                errors;
	int                pending;
	int                checked_count;
	int                peeked_count;
	int                overflow_count;
	int unsigned       ring_span;
	int unsigned       head_at;
	int unsigned       bytes_held;
	logic [4095:0]     byte_written;
	int                cmd_count = 0;
	int                size_writes = 0;

	tbrb_req_if req_ch ();
	tbrb_rsp_if rsp_ch ();

	tcp_byte_ring_buffer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	tcp_byte_ring_buffer_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.errors         (errors),
		.pending        (pending),
		.checked_count  (checked_count),
		.peeked_count   (peeked_count),
		.overflow_count (overflow_count),
		.ring_span      (ring_span),
		.head_at        (head_at),
		.bytes_held     (bytes_held),
		.byte_written   (byte_written)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("FAILURE");
		$finish;
	end

	// result side stalls in short bursts until the calm part of the run
	initial begin
		rsp_ch.ready = 1'b1;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready = 1'b1;
				if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 5);
			end
		end
	end

	// called and returns at a falling edge; valid stays up for a back-to-back item
	task automatic send_item(logic [CMD_W-1:0] command, int unsigned offset,
		int unsigned amount, logic [DATA_W-1:0] data);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.command = command;
		req_ch.offset = SIZE_W'(offset);
		req_ch.amount = AMT_W'(amount);
		req_ch.data_in = data;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		if (command <= CMD_REMOVE) cmd_count++;
	endtask

	task automatic send_peek(int unsigned offset, int unsigned amount);
		int unsigned k, pos;
		k = 0;
		// stop short of bytes that were committed but never stored
		while (k < amount && k < PEEK_MAX && offset + k < bytes_held) begin
			pos = head_at + offset + k;
			if (pos >= ring_span) pos -= ring_span;
			if (!byte_written[12'(pos)]) break;
			k++;
		end
		if (k < amount && k < PEEK_MAX && offset + k < bytes_held) amount = k;
		send_item(CMD_PEEK, offset, amount, {$urandom, $urandom});
	endtask

	task automatic write_size(logic [SIZE_W-1:0] value);
		req_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {REG_BUFFER_SIZE, 2'b00};
		pwdata = {19'($urandom), value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		size_writes++;
	endtask

	// segments of one receive arrive out of order, then get committed
	task automatic send_segments();
		int unsigned segs, last_len, total, j, pick, tmp;
		int unsigned order [3];
		segs = $urandom_range(1, 3);
		last_len = $urandom_range(1, WRITE_MAX);
		total = (segs - 1) * WRITE_MAX + last_len;
		for (j = 0; j < segs; j++) order[j] = j;
		for (j = segs - 1; j > 0; j--) begin
			pick = $urandom_range(0, j);
			tmp = order[j];
			order[j] = order[pick];
			order[pick] = tmp;
		end
		for (j = 0; j < segs; j++)
			send_item(CMD_RWRITE, order[j] * WRITE_MAX,
				(order[j] == segs - 1) ? last_len : WRITE_MAX, {$urandom, $urandom});
		case ($urandom_range(0, 7))
			0: send_item(CMD_COMMIT, $urandom_range(1, 4), total, {$urandom, $urandom});
			1: send_item(CMD_COMMIT, 0, AMOUNT_TOP, {$urandom, $urandom});
			default: send_item(CMD_COMMIT, 0, total, {$urandom, $urandom});
		endcase
	endtask

	task automatic random_item();
		int unsigned r, space, off;
		r = $urandom_range(0, 99);
		space = ring_span - bytes_held;
		off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, OFFSET_TOP)
			: $urandom_range(0, space + 1);
		if (r < 30)
			send_segments();
		else if (r < 50)
			send_item(CMD_APPEND, $urandom_range(0, OFFSET_TOP),
				($urandom_range(0, 7) == 0) ? $urandom_range(WRITE_MAX + 1, AMOUNT_TOP)
				: $urandom_range(0, WRITE_MAX), {$urandom, $urandom});
		else if (r < 72)
			send_peek(($urandom_range(0, 7) == 0) ? $urandom_range(0, OFFSET_TOP)
				: $urandom_range(0, bytes_held + 2),
				($urandom_range(0, 7) == 0) ? $urandom_range(PEEK_MAX + 1, AMOUNT_TOP)
				: $urandom_range(0, PEEK_MAX));
		else if (r < 84)
			send_item(CMD_REMOVE, $urandom_range(0, OFFSET_TOP),
				($urandom_range(0, 5) == 0) ? $urandom_range(0, AMOUNT_TOP)
				: $urandom_range(0, 16), {$urandom, $urandom});
		else if (r < 90)
			send_item(CMD_COMMIT, off, $urandom_range(0, AMOUNT_TOP), {$urandom, $urandom});
		else if (r < 96)
			send_item(CMD_RWRITE, off, $urandom_range(0, 15), {$urandom, $urandom});
		else
			send_item(CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)),
				$urandom_range(0, OFFSET_TOP), $urandom_range(0, AMOUNT_TOP),
				{$urandom, $urandom});
	endtask

	task automatic run_phase(logic [SIZE_W-1:0] size, int count);
		int start;
		write_size(size);
		start = cmd_count;
		while (cmd_count - start < count) random_item();
	endtask

	initial begin
		int c;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_APPEND;
		req_ch.offset = '0;
		req_ch.amount = '0;
		req_ch.data_in = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed corners on the full-size ring
		write_size(SIZE_W'(SIZE_RESET));
		send_item(CMD_APPEND, 0, WRITE_MAX, '1);
		send_item(CMD_APPEND, OFFSET_TOP, WRITE_MAX, '0);
		send_item(CMD_APPEND, 0, 0, {$urandom, $urandom});
		send_item(CMD_APPEND, 0, AMOUNT_TOP, {$urandom, $urandom});
		send_peek(0, PEEK_MAX);
		send_peek(0, 0);
		send_peek(OFFSET_TOP, 1);
		send_peek(23, AMOUNT_TOP);
		send_item(CMD_RWRITE, 8, WRITE_MAX, {$urandom, $urandom});
		send_item(CMD_RWRITE, 0, WRITE_MAX, {$urandom, $urandom});
		send_item(CMD_COMMIT, 0, 16, {$urandom, $urandom});
		// receive write straddling the end of free space
		send_item(CMD_RWRITE, ring_span - bytes_held - 3, WRITE_MAX, {$urandom, $urandom});
		send_item(CMD_RWRITE, OFFSET_TOP, WRITE_MAX, {$urandom, $urandom});
		send_item(CMD_COMMIT, OFFSET_TOP, 5, {$urandom, $urandom});
		send_item(CMD_COMMIT, 0, 0, {$urandom, $urandom});
		send_item(CMD_COMMIT, 5, 0, {$urandom, $urandom});
		send_item(CMD_REMOVE, 0, AMOUNT_TOP, {$urandom, $urandom});
		send_item(CMD_REMOVE, 0, 0, {$urandom, $urandom});
		send_peek(0, PEEK_MAX);
		for (c = int'(CMD_UNKNOWN_LO); c <= int'(CMD_UNKNOWN_HI); c++)
			send_item(CMD_W'(c), OFFSET_TOP, AMOUNT_TOP, '1);

		run_phase(SIZE_W'(16), 20);
		run_phase(SIZE_W'(1), 12);
		run_phase(SIZE_W'(0), 10);
		run_phase(SIZE_W'(OFFSET_TOP), 20);
		run_phase(SIZE_W'(SIZE_RESET + 1), 16);
		run_phase(SIZE_W'($urandom_range(2, 64)), 24);
		calm = 1'b1;
		run_phase(SIZE_W'(SIZE_RESET), 28);

		req_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("run covered %0d commands over %0d buffer size settings",
			cmd_count, size_writes);
		$display("%0d result items checked, %0d bytes peeked, %0d overflow flags",
			checked_count, peeked_count, overflow_count);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
